@@ design/tvw_pkg.sv @@
`timescale 1ns / 1ps

package tvw_pkg;

  // Table geometry
  localparam int MAX_VERTICES = 4096;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W        = 13;
  localparam int COORD_W      = 32;
  localparam int RADIUS_W     = 31;
  localparam int R2_W         = 2 * RADIUS_W;
  localparam int MAG_W        = COORD_W + 1;
  localparam int SQ_W         = 2 * COORD_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam int FRONT_DEPTH  = 2;

  // One stored vertex
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  // One input triangle
  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } face_t;

  // One welded face
  typedef struct packed {
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic             status;
  } result_t;

  // Head of the front queue, seen by the back end
  typedef struct packed {
    logic  valid;
    face_t face;
  } front_head_t;

  // Table entry entering the distance pipeline
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] idx;
    vertex_t          entry;
  } dist_req_t;

  // Compare result leaving the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             match;
    logic [CNT_W-1:0] idx;
    logic             busy;
  } dist_res_t;

endpackage

@@ design/tvw_front.sv @@
`timescale 1ns / 1ps

module tvw_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  tvw_pkg::face_t       face,
  input  logic                 head_pop,
  output tvw_pkg::front_head_t head
);

  localparam int PTR_W = $clog2(tvw_pkg::FRONT_DEPTH);
  localparam int FCNT_W = $clog2(tvw_pkg::FRONT_DEPTH + 1);

  tvw_pkg::face_t     slots [tvw_pkg::FRONT_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign full    = (fill == FCNT_W'(tvw_pkg::FRONT_DEPTH));
  assign do_push = push & ~full;
  assign do_pop  = head_pop & (fill != '0);

  assign head.valid = (fill != '0);
  assign head.face  = slots[rd_ptr];

  // Slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= face;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(tvw_pkg::FRONT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(tvw_pkg::FRONT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    fill <= FCNT_W'(tvw_pkg::FRONT_DEPTH))
    else $error("front queue overfilled");

  assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (wr_ptr == rd_ptr))
    else $error("front queue pointers disagree when empty");

  assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + 1'b1))
    else $error("front queue lost a transfer");

endmodule

@@ design/tvw_dist.sv @@
`timescale 1ns / 1ps

module tvw_dist (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          flush,
  input  tvw_pkg::vertex_t              vertex,
  input  logic [tvw_pkg::R2_W-1:0]      r2,
  input  tvw_pkg::dist_req_t            req,
  output tvw_pkg::dist_res_t            res
);

  localparam int MAG_W = tvw_pkg::MAG_W;
  localparam int CW    = tvw_pkg::COORD_W;

  // Stage 1: per-axis magnitude of the difference
  logic                      s1_valid;
  logic [tvw_pkg::CNT_W-1:0] s1_idx;
  logic [MAG_W-1:0]          s1_mag [3];

  // Stage 2: squares and overflow flag
  logic                      s2_valid;
  logic [tvw_pkg::CNT_W-1:0] s2_idx;
  logic [tvw_pkg::SQ_W-1:0]  s2_sq [3];
  logic                      s2_sat;

  // Stage 3: sum of squares
  logic                      s3_valid;
  logic [tvw_pkg::CNT_W-1:0] s3_idx;
  logic [tvw_pkg::SUM_W-1:0] s3_sum;
  logic                      s3_sat;

  // Stage 4: compare against radius squared
  logic                      s4_valid;
  logic [tvw_pkg::CNT_W-1:0] s4_idx;
  logic                      s4_match;

  logic signed [CW-1:0] va [3];
  logic signed [CW-1:0] sa [3];
  logic [MAG_W-1:0]     mag [3];

  assign va[0] = vertex.x;
  assign va[1] = vertex.y;
  assign va[2] = vertex.z;
  assign sa[0] = req.entry.x;
  assign sa[1] = req.entry.y;
  assign sa[2] = req.entry.z;

  // Both subtraction orders in parallel, pick the non-negative one
  always_comb begin
    logic [MAG_W-1:0] dp;
    logic [MAG_W-1:0] dn;
    for (int k = 0; k < 3; k++) begin
      dp = {va[k][CW-1], va[k]} - {sa[k][CW-1], sa[k]};
      dn = {sa[k][CW-1], sa[k]} - {va[k][CW-1], va[k]};
      mag[k] = dp[MAG_W-1] ? dn : dp;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    s1_idx <= req.idx;
    for (int k = 0; k < 3; k++) begin
      s1_mag[k] <= mag[k];
    end

    s2_idx <= s1_idx;
    for (int k = 0; k < 3; k++) begin
      s2_sq[k] <= s1_mag[k][CW-1:0] * s1_mag[k][CW-1:0];
    end
    s2_sat <= s1_mag[0][MAG_W-1] | s1_mag[1][MAG_W-1] | s1_mag[2][MAG_W-1];

    s3_idx <= s2_idx;
    s3_sum <= {2'b00, s2_sq[0]} + {2'b00, s2_sq[1]} + {2'b00, s2_sq[2]};
    s3_sat <= s2_sat;

    // a saturated distance is never below the radius
    s4_idx   <= s3_idx;
    s4_match <= ~s3_sat &
                (s3_sum < {{(tvw_pkg::SUM_W - tvw_pkg::R2_W){1'b0}}, r2});
  end

  assign res.valid = s4_valid;
  assign res.match = s4_match;
  assign res.idx   = s4_idx;
  assign res.busy  = s1_valid | s2_valid | s3_valid | s4_valid;

  assert property (@(posedge clk) disable iff (rst)
    flush |=> !res.busy)
    else $error("distance pipeline kept work after flush");

  assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !flush) |=> s4_valid)
    else $error("compare stage dropped a valid entry");

  assert property (@(posedge clk) disable iff (rst)
    (s4_valid && s3_valid) |-> (s3_idx == s4_idx + 1'b1))
    else $error("entries left the pipeline out of order");

endmodule

@@ design/tvw_engine.sv @@
`timescale 1ns / 1ps

module tvw_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          radius_we,
  input  logic [tvw_pkg::RADIUS_W-1:0]  radius,
  input  tvw_pkg::front_head_t          head,
  output logic                          head_pop,
  output logic                          empty,
  input  logic                          pop,
  output tvw_pkg::result_t              result
);

  localparam int CNT_W = tvw_pkg::CNT_W;
  localparam int IDX_W = tvw_pkg::IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  logic [tvw_pkg::RADIUS_W-1:0] match_radius;
  logic [tvw_pkg::R2_W-1:0]     r2;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             scan_idx;
  logic [1:0]                   vsel;
  logic [IDX_W-1:0]             idx_a;
  logic [IDX_W-1:0]             idx_b;
  logic [IDX_W-1:0]             idx_c;
  logic                         dropped;
  logic                         out_valid;
  tvw_pkg::result_t             out_data;

  tvw_pkg::vertex_t             mem [tvw_pkg::MAX_VERTICES];
  tvw_pkg::vertex_t             rd_entry;
  logic                         rd_valid;
  logic [CNT_W-1:0]             rd_idx;

  tvw_pkg::vertex_t             vertex;
  tvw_pkg::dist_req_t           req;
  tvw_pkg::dist_res_t           res;

  logic in_scan;
  logic hit;
  logic drained;
  logic miss;
  logic issue;
  logic room;
  logic vertex_done;
  logic append;
  logic emit;
  logic [CNT_W-1:0] placed_idx;

  // Current vertex of the head triangle
  always_comb begin
    unique case (vsel)
      2'd0:    vertex = '{x: head.face.a_x, y: head.face.a_y, z: head.face.a_z};
      2'd1:    vertex = '{x: head.face.b_x, y: head.face.b_y, z: head.face.b_z};
      2'd2:    vertex = '{x: head.face.c_x, y: head.face.c_y, z: head.face.c_z};
      default: vertex = '{x: head.face.c_x, y: head.face.c_y, z: head.face.c_z};
    endcase
  end

  // Scan control
  assign in_scan     = (state == ST_SCAN);
  assign room        = (count < CNT_W'(tvw_pkg::MAX_VERTICES));
  assign hit         = in_scan & res.valid & res.match;
  assign drained     = (scan_idx == count) & ~rd_valid & ~res.busy;
  assign miss        = in_scan & ~hit & drained;
  assign issue       = in_scan & ~hit & (scan_idx < count);
  assign vertex_done = hit | miss;
  assign append      = miss & room;
  assign placed_idx  = hit ? res.idx : (room ? count : CNT_W'(tvw_pkg::MAX_VERTICES));
  assign emit        = (state == ST_EMIT) & (~out_valid | pop);
  assign head_pop    = emit;

  // Vertex table
  always_ff @(posedge clk) begin
    if (append) begin
      mem[count[tvw_pkg::ADDR_W-1:0]] <= vertex;
    end
    rd_entry <= mem[scan_idx[tvw_pkg::ADDR_W-1:0]];
    rd_idx   <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst || hit) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  assign req.valid = rd_valid;
  assign req.idx   = rd_idx;
  assign req.entry = rd_entry;

  tvw_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .flush  (hit),
    .vertex (vertex),
    .r2     (r2),
    .req    (req),
    .res    (res)
  );

  // Radius register and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      match_radius <= tvw_pkg::RADIUS_W'(1);
    end else if (radius_we) begin
      match_radius <= radius;
    end
    r2 <= match_radius * match_radius;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (head.valid) state_next = ST_SCAN;
      ST_SCAN: if (vertex_done && vsel == 2'd2) state_next = ST_EMIT;
      ST_EMIT: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      scan_idx <= '0;
      vsel     <= '0;
      dropped  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        scan_idx <= '0;
        vsel     <= '0;
        dropped  <= 1'b0;
      end else if (vertex_done) begin
        scan_idx <= '0;
        vsel     <= vsel + 1'b1;
        if (miss && !room) begin
          dropped <= 1'b1;
        end
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (append) begin
        count <= count + 1'b1;
      end
    end
  end

  // Per-vertex indices
  always_ff @(posedge clk) begin
    if (vertex_done) begin
      case (vsel)
        2'd0:    idx_a <= IDX_W'(placed_idx);
        2'd1:    idx_b <= IDX_W'(placed_idx);
        default: idx_c <= IDX_W'(placed_idx);
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= '{index_a: idx_a, index_b: idx_b, index_c: idx_c, status: dropped};
    end
  end

  assign empty  = ~out_valid;
  assign result = out_data;

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(tvw_pkg::MAX_VERTICES))
    else $error("stored count past table capacity");

  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + 1'b1))
    else $error("stored count moved by more than one");

  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == ST_SCAN))
    else $error("compare result outside a scan");

  assert property (@(posedge clk) disable iff (rst)
    in_scan |-> (scan_idx <= count))
    else $error("scan ran past the stored entries");

  assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head.valid)
    else $error("front queue popped while empty");

endmodule

@@ design/triangle_vertex_welding.sv @@
`timescale 1ns / 1ps

// Triangle vertex welding.
// Input channel: a triangle (three signed Q16.16 vertices) transfers on a
// clock edge with push high and full low. A two-entry front queue holds
// triangles so the sender can keep going while the back end scans.
// Result channel: while empty is low, result holds the oldest face (three
// table indices and a drop flag); it transfers on an edge with pop high.
// radius_we writes match_radius; write it only while the block is idle.
// Each vertex streams the stored entries through the distance
// pipeline one per cycle; the scan of a vertex ends at its first match,
// and one that matches nothing waits until every stored entry has been
// compared and the pipeline has drained (straight away on an empty table).
// A triangle is done once all three of its vertices are; with a full
// table of 4096 entries, the scan of the vertex table, one read port
// entry per cycle, sets the time that a triangle takes.
// Reset empties the table (stored count zero), sets match_radius to 1 and
// clears both queues; the table needs no clearing pass.
// When the receiver stalls, the finished face waits in the result register,
// the next triangle is still welded and then waits for that register.

module triangle_vertex_welding (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  tvw_pkg::face_t                face,
  output logic                          empty,
  input  logic                          pop,
  output tvw_pkg::result_t              result,
  input  logic                          radius_we,
  input  logic [tvw_pkg::RADIUS_W-1:0]  radius
);

  tvw_pkg::front_head_t head;
  logic                 head_pop;

  tvw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .face     (face),
    .head_pop (head_pop),
    .head     (head)
  );

  tvw_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .radius_we (radius_we),
    .radius    (radius),
    .head      (head),
    .head_pop  (head_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
